FILE: src/rprq_pkg.sv
// Types and codes for the read priority request queue.
// Used by the cell chain, the top level and the checker; no dependencies.
`default_nettype none
package rprq_pkg;

    localparam int ADDR_W = 48;
    localparam int POS_W  = 8;

    localparam logic [1:0] CMD_ENQ   = 2'd0;
    localparam logic [1:0] CMD_DEQ   = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;
    localparam logic [1:0] CMD_NOP   = 2'd3;

    localparam logic [1:0] PL_TAIL    = 2'd0;
    localparam logic [1:0] PL_HEAD    = 2'd1;
    localparam logic [1:0] PL_ORDERED = 2'd2;
    localparam logic [1:0] PL_ALT     = 2'd3;

    localparam logic [2:0] ST_QUEUED   = 3'd0;
    localparam logic [2:0] ST_REJECTED = 3'd1;
    localparam logic [2:0] ST_DEQUEUED = 3'd2;
    localparam logic [2:0] ST_EMPTY    = 3'd3;
    localparam logic [2:0] ST_CLEARED  = 3'd4;

    localparam logic [7:0] REG_INTERVAL = 8'd0;
    localparam logic [7:0] REG_BUDGET   = 8'd1;

    localparam logic [7:0]  INTERVAL_RST = 8'd16;
    localparam logic [23:0] BUDGET_RST   = 24'd2048;

    typedef struct packed {
        logic [1:0]        command;
        logic [1:0]        placement;
        logic              is_write;
        logic              in_composite;
        logic [ADDR_W-1:0] block_address;
        logic [15:0]       sector_count;
        logic [7:0]        request_tag;
    } t_in_item;

    typedef struct packed {
        logic [2:0]        status;
        logic [7:0]        out_tag;
        logic              out_is_write;
        logic [ADDR_W-1:0] out_block_address;
        logic [15:0]       out_sector_count;
        logic [5:0]        occupancy;
    } t_out_item;

    typedef struct packed {
        logic              is_write;
        logic [ADDR_W-1:0] address;
        logic [15:0]       count;
        logic [7:0]        tag;
    } t_entry;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_REMOVE
    } t_cell_op;

    typedef struct packed {
        t_cell_op         op;
        logic [POS_W-1:0] pos;
    } t_cell_ctl;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_WALK,
        S_DONE
    } t_state;

endpackage
`default_nettype wire

FILE: src/rprq_cell.sv
// One queue position of the request chain: holds, takes the new entry or its
// left neighbor on insert, the right one on removal. Depends on rprq_pkg.
`default_nettype none
module rprq_cell #(
    parameter int IDX = 0
) (
    input  wire                      i_clk,
    input  wire rprq_pkg::t_cell_ctl i_ctl,
    input  wire rprq_pkg::t_entry    i_new,
    input  wire rprq_pkg::t_entry    i_left,
    input  wire rprq_pkg::t_entry    i_right,
    output rprq_pkg::t_entry         o_data
);

    localparam logic [rprq_pkg::POS_W:0] IDX_V = (rprq_pkg::POS_W + 1)'(IDX);

    rprq_pkg::t_entry r_data;
    rprq_pkg::t_entry n_data;
    logic [rprq_pkg::POS_W:0] pos_x;

    assign pos_x = {1'b0, i_ctl.pos};

    always_comb begin
        n_data = r_data;
        case (i_ctl.op)
            rprq_pkg::CELL_INSERT: begin
                if (IDX_V == pos_x) begin
                    n_data = i_new;
                end else if (IDX_V > pos_x) begin
                    n_data = i_left;
                end
            end
            rprq_pkg::CELL_REMOVE: n_data = i_right;
            default: n_data = r_data;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule
`default_nettype wire

FILE: src/read_priority_request_queue.sv
// Read priority request queue top level: control sequencer, transition walk
// and the chain of rprq_cell positions. Depends on rprq_pkg and rprq_cell.
//
//  channel | dir | handshake                    | payload
//  in      | in  | i_in_valid / o_in_ready      | i_in_item  (t_in_item)
//  out     | out | o_out_valid / i_out_ready    | o_out_item (t_out_item)
//  cfg     | in  | i_cfg_valid / o_cfg_ready    | i_cfg_index, i_cfg_data
//
// One request at a time: the request is taken in idle and executed, then a
// transition walk may step over entries until an address break, the end of
// the queue or the budget stops it, and the result is held until taken.
// The walk reads one chain position per cycle.
// Synchronous active-low reset empties the queue; no clearing pass.
// A stalled result holds the block; config is always ready.
`default_nettype none
module read_priority_request_queue #(
    parameter int QUEUE_DEPTH = 32
) (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_in_valid,
    output logic                     o_in_ready,
    input  wire rprq_pkg::t_in_item  i_in_item,
    output logic                     o_out_valid,
    input  wire                      i_out_ready,
    output rprq_pkg::t_out_item      o_out_item,
    input  wire                      i_cfg_valid,
    output logic                     o_cfg_ready,
    input  wire [7:0]                i_cfg_index,
    input  wire [23:0]               i_cfg_data
);

    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam logic [CW-1:0] FULL_V = CW'(QUEUE_DEPTH);

    rprq_pkg::t_state    r_state, n_state;
    rprq_pkg::t_in_item  r_req;
    rprq_pkg::t_out_item r_out, n_out;
    logic [CW-1:0]       r_count, n_count;
    logic [CW-1:0]       r_tp, n_tp;
    logic                r_tp_v, n_tp_v;
    logic [7:0]          r_rc, n_rc;
    logic [7:0]          r_interval;
    logic [23:0]         r_budget;
    logic [23:0]         r_left, n_left;
    logic [rprq_pkg::ADDR_W-1:0] r_expect, n_expect;
    logic                r_first, n_first;
    logic                walk_go, walk_end;
    logic [7:0]          rc_inc;

    rprq_pkg::t_cell_ctl cell_ctl;
    rprq_pkg::t_entry    cells [QUEUE_DEPTH];
    rprq_pkg::t_entry    new_entry;
    rprq_pkg::t_entry    rd;

    assign new_entry.is_write = r_req.is_write;
    assign new_entry.address  = r_req.block_address;
    assign new_entry.count    = r_req.sector_count;
    assign new_entry.tag      = r_req.request_tag;

    genvar g;
    generate
        for (g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
            rprq_cell #(.IDX(g)) u_cell (
                .i_clk   (i_clk),
                .i_ctl   (cell_ctl),
                .i_new   (new_entry),
                .i_left  ((g == 0) ? new_entry : cells[(g == 0) ? 0 : g - 1]),
                .i_right ((g == QUEUE_DEPTH - 1) ? cells[g]
                          : cells[(g == QUEUE_DEPTH - 1) ? g : g + 1]),
                .o_data  (cells[g])
            );
        end
    endgenerate

    assign rd     = cells[r_tp[PW-1:0]];
    assign rc_inc = r_rc + 8'd1;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            rprq_pkg::S_IDLE: if (i_in_valid) n_state = rprq_pkg::S_EXEC;
            rprq_pkg::S_EXEC: n_state = walk_go ? rprq_pkg::S_WALK : rprq_pkg::S_DONE;
            rprq_pkg::S_WALK: if (walk_end) n_state = rprq_pkg::S_DONE;
            rprq_pkg::S_DONE: if (i_out_ready) n_state = rprq_pkg::S_IDLE;
            default: n_state = rprq_pkg::S_IDLE;
        endcase
    end

    // datapath decisions
    always_comb begin
        cell_ctl  = '{op: rprq_pkg::CELL_HOLD, pos: '0};
        n_out     = r_out;
        n_count   = r_count;
        n_tp      = r_tp;
        n_tp_v    = r_tp_v;
        n_rc      = r_rc;
        n_left    = r_left;
        n_expect  = r_expect;
        n_first   = r_first;
        walk_go   = 1'b0;
        walk_end  = 1'b0;
        case (r_state)
            rprq_pkg::S_EXEC: begin
                n_out = '0;
                n_out.status = rprq_pkg::ST_QUEUED;
                case (r_req.command)
                    rprq_pkg::CMD_ENQ: begin
                        if (r_count == FULL_V) begin
                            n_out.status = rprq_pkg::ST_REJECTED;
                        end else begin
                            n_count = r_count + 1'b1;
                            cell_ctl.op  = rprq_pkg::CELL_INSERT;
                            cell_ctl.pos = rprq_pkg::POS_W'(r_count);
                            if (r_req.placement == rprq_pkg::PL_HEAD) begin
                                cell_ctl.pos = '0;
                                if (r_tp_v) n_tp = r_tp + 1'b1;
                            end else if (r_req.placement == rprq_pkg::PL_ORDERED) begin
                                if (!r_req.is_write) begin
                                    if (r_tp_v) begin
                                        cell_ctl.pos = rprq_pkg::POS_W'(r_tp);
                                        n_tp = r_tp + 1'b1;
                                        n_rc = rc_inc;
                                        if (rc_inc >= r_interval) begin
                                            n_rc    = '0;
                                            walk_go = !r_req.in_composite;
                                        end
                                    end
                                end else if (!r_tp_v) begin
                                    n_tp   = r_count;
                                    n_tp_v = 1'b1;
                                end
                                if (r_req.in_composite) begin
                                    n_tp_v = 1'b0;
                                    n_rc   = '0;
                                end
                            end else begin
                                n_tp_v = 1'b0;
                            end
                        end
                    end
                    rprq_pkg::CMD_DEQ: begin
                        if (r_count == '0) begin
                            n_out.status = rprq_pkg::ST_EMPTY;
                        end else begin
                            n_out.status            = rprq_pkg::ST_DEQUEUED;
                            n_out.out_tag           = cells[0].tag;
                            n_out.out_is_write      = cells[0].is_write;
                            n_out.out_block_address = cells[0].address;
                            n_out.out_sector_count  = cells[0].count;
                            cell_ctl.op = rprq_pkg::CELL_REMOVE;
                            n_count = r_count - 1'b1;
                            if (r_tp_v) begin
                                if (r_tp == '0) n_tp_v = (r_count > CW'(1));
                                else n_tp = r_tp - 1'b1;
                            end
                        end
                    end
                    rprq_pkg::CMD_CLEAR: begin
                        n_out.status = rprq_pkg::ST_CLEARED;
                        n_count = '0;
                        n_tp_v  = 1'b0;
                        n_rc    = '0;
                    end
                    default: n_out.status = rprq_pkg::ST_QUEUED;
                endcase
                n_out.occupancy = 6'(n_count);
                n_left  = r_budget;
                n_first = 1'b1;
            end
            rprq_pkg::S_WALK: begin
                n_first = 1'b0;
                if (!r_tp_v || r_tp >= r_count
                    || (!r_first && rd.address != r_expect)) begin
                    walk_end = 1'b1;
                end else begin
                    n_expect = rprq_pkg::ADDR_W'(rd.address
                               + rprq_pkg::ADDR_W'(rd.count));
                    n_tp = r_tp + 1'b1;
                    if (r_tp + 1'b1 >= r_count) n_tp_v = 1'b0;
                    if (r_left < 24'(rd.count)) walk_end = 1'b1;
                    else n_left = r_left - 24'(rd.count);
                end
            end
            default: cell_ctl = '{op: rprq_pkg::CELL_HOLD, pos: '0};
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= rprq_pkg::S_IDLE;
            r_count    <= '0;
            r_tp_v     <= 1'b0;
            r_rc       <= '0;
            r_interval <= rprq_pkg::INTERVAL_RST;
            r_budget   <= rprq_pkg::BUDGET_RST;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_tp_v  <= n_tp_v;
            r_rc    <= n_rc;
            if (i_cfg_valid) begin
                if (i_cfg_index == rprq_pkg::REG_INTERVAL) r_interval <= i_cfg_data[7:0];
                else if (i_cfg_index == rprq_pkg::REG_BUDGET) r_budget <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == rprq_pkg::S_IDLE && i_in_valid) r_req <= i_in_item;
        r_out    <= n_out;
        r_tp     <= n_tp;
        r_left   <= n_left;
        r_expect <= n_expect;
        r_first  <= n_first;
    end

    assign o_in_ready  = (r_state == rprq_pkg::S_IDLE);
    assign o_out_valid = (r_state == rprq_pkg::S_DONE);
    assign o_out_item  = r_out;
    assign o_cfg_ready = 1'b1;

endmodule
`default_nettype wire

FILE: src/rprq_checker.sv
// Port-level checks for the read priority request queue, bound to the top.
// Depends on rprq_pkg.
`default_nettype none
module rprq_checker (
    input wire                      i_clk,
    input wire                      i_rst_n,
    input wire                      i_in_valid,
    input wire                      o_in_ready,
    input wire                      o_out_valid,
    input wire                      i_out_ready,
    input wire rprq_pkg::t_out_item o_out_item
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped before transfer");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("second request taken while busy");

    a_zero_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.status != rprq_pkg::ST_DEQUEUED
        |-> o_out_item.out_tag == 8'd0 && o_out_item.out_block_address == '0)
        else $error("payload fields set without dequeue");

    a_clear_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_item.status == rprq_pkg::ST_CLEARED
                        || o_out_item.status == rprq_pkg::ST_EMPTY)
        |-> o_out_item.occupancy == 6'd0)
        else $error("nonzero occupancy after clear or empty dequeue");

endmodule

bind read_priority_request_queue rprq_checker u_rprq_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_item  (o_out_item)
);
`default_nettype wire

FILE: tb/read_priority_request_queue_checker.sv
// Checker for the read priority request queue: watches the request, result and
// configuration channels, predicts every result and compares. Depends on rprq_pkg.
module read_priority_request_queue_checker (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_in_valid,
    input  wire                  i_in_ready,
    input  rprq_pkg::t_in_item   i_in_item,
    input  wire                  i_out_valid,
    input  wire                  i_out_ready,
    input  rprq_pkg::t_out_item  i_out_item,
    input  wire                  i_cfg_valid,
    input  wire                  i_cfg_ready,
    input  wire [7:0]            i_cfg_index,
    input  wire [23:0]           i_cfg_data,
    output int                   o_fail_count,
    output int                   o_pending
);

    localparam int DEPTH = 32;
    localparam logic [5:0] NIL = 6'd32;

    logic [rprq_pkg::ADDR_W-1:0] slot_addr [DEPTH];
    logic              slot_wr [DEPTH];
    logic [15:0]       slot_cnt [DEPTH];
    logic [7:0]        slot_tag [DEPTH];
    logic [5:0]        nxt [DEPTH];
    logic [5:0]        prv [DEPTH];
    logic              slot_free [DEPTH];
    logic [5:0]        head, tail, trans;
    logic [7:0]        read_count;
    logic [5:0]        total;
    logic [7:0]        interval;
    logic [23:0]       budget;

    rprq_pkg::t_out_item expected_results[$];

    task automatic empty_queue();
        for (int i = 0; i < DEPTH; i++) slot_free[i] = 1'b1;
        head = NIL;
        tail = NIL;
        trans = NIL;
        read_count = '0;
        total = '0;
    endtask

    task automatic link_tail(input logic [5:0] s);
        nxt[s] = NIL;
        prv[s] = tail;
        if (tail != NIL) nxt[tail] = s;
        else head = s;
        tail = s;
    endtask

    task automatic advance_transition();
        logic [24:0] left;
        logic [rprq_pkg::ADDR_W-1:0] want;
        logic [5:0] s;
        left = {1'b0, budget};
        if (trans == NIL) return;
        want = slot_addr[trans];
        for (int i = 0; i < DEPTH; i++) begin
            s = trans;
            if (s == NIL || slot_addr[s] != want) break;
            want = slot_addr[s] + slot_cnt[s];
            trans = nxt[s];
            if (left < slot_cnt[s]) break;
            left = left - slot_cnt[s];
        end
    endtask

    task automatic predict_request(input rprq_pkg::t_in_item it);
        rprq_pkg::t_out_item r;
        logic [5:0] s, p;
        r = '0;
        if (it.command == rprq_pkg::CMD_ENQ) begin
            s = NIL;
            for (int i = 0; i < DEPTH; i++) begin
                if (slot_free[i]) begin
                    s = 6'(i);
                    break;
                end
            end
            if (s == NIL) begin
                r.status = rprq_pkg::ST_REJECTED;
            end else begin
                slot_free[s] = 1'b0;
                slot_addr[s] = it.block_address;
                slot_wr[s] = it.is_write;
                slot_cnt[s] = it.sector_count;
                slot_tag[s] = it.request_tag;
                total++;
                if (it.placement == rprq_pkg::PL_HEAD) begin
                    prv[s] = NIL;
                    nxt[s] = head;
                    if (head != NIL) prv[head] = s;
                    else tail = s;
                    head = s;
                end else if (it.placement == rprq_pkg::PL_ORDERED) begin
                    if (!it.is_write) begin
                        if (trans != NIL) begin
                            p = prv[trans];
                            nxt[s] = trans;
                            prv[s] = p;
                            prv[trans] = s;
                            if (p != NIL) nxt[p] = s;
                            else head = s;
                            read_count++;
                            if (read_count >= interval) begin
                                read_count = '0;
                                advance_transition();
                            end
                        end else begin
                            link_tail(s);
                        end
                    end else begin
                        link_tail(s);
                        if (trans == NIL) trans = s;
                    end
                    if (it.in_composite) begin
                        trans = NIL;
                        read_count = '0;
                    end
                end else begin
                    link_tail(s);
                    trans = NIL;
                end
                r.status = rprq_pkg::ST_QUEUED;
            end
        end else if (it.command == rprq_pkg::CMD_DEQ) begin
            s = head;
            if (s == NIL) begin
                r.status = rprq_pkg::ST_EMPTY;
            end else begin
                if (trans == s) trans = nxt[s];
                head = nxt[s];
                if (head != NIL) prv[head] = NIL;
                else tail = NIL;
                slot_free[s] = 1'b1;
                if (total > 0) total--;
                r.status = rprq_pkg::ST_DEQUEUED;
                r.out_tag = slot_tag[s];
                r.out_is_write = slot_wr[s];
                r.out_block_address = slot_addr[s];
                r.out_sector_count = slot_cnt[s];
            end
        end else if (it.command == rprq_pkg::CMD_CLEAR) begin
            empty_queue();
            r.status = rprq_pkg::ST_CLEARED;
        end else begin
            r.status = rprq_pkg::ST_QUEUED;
        end
        r.occupancy = total;
        expected_results.push_back(r);
    endtask

    always @(posedge i_clk) begin
        rprq_pkg::t_out_item e;
        if (!i_rst_n) begin
            empty_queue();
            interval <= rprq_pkg::INTERVAL_RST;
            budget <= rprq_pkg::BUDGET_RST;
            expected_results.delete();
            o_fail_count <= 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == rprq_pkg::REG_INTERVAL) interval <= i_cfg_data[7:0];
                else if (i_cfg_index == rprq_pkg::REG_BUDGET) budget <= i_cfg_data;
            end
            if (i_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    if (o_fail_count < 10)
                        $display("unexpected result %h", i_out_item);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    e = expected_results.pop_front();
                    if (e !== i_out_item) begin
                        if (o_fail_count < 10)
                            $display("mismatch: expected %h actual %h", e, i_out_item);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            if (i_in_valid && i_in_ready) predict_request(i_in_item);
        end
        o_pending <= expected_results.size();
    end
endmodule

FILE: tb/read_priority_request_queue_test.sv
// Testbench top for the read priority request queue: clock, reset, directed and
// random request stimulus, config phases and verdict. Depends on rprq_pkg, the queue and the checker.
module read_priority_request_queue_test;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_ready;
    rprq_pkg::t_in_item i_in_item = '0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    rprq_pkg::t_out_item o_out_item;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [7:0] i_cfg_index = '0;
    logic [23:0] i_cfg_data = '0;
    int fail_count;
    int pending;
    int cycles = 0;
    int send_idle = 0;
    int stall_pct = 0;
    logic [rprq_pkg::ADDR_W-1:0] run_addr;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    read_priority_request_queue dut (.*);

    read_priority_request_queue_checker checker_inst (
        .i_clk, .i_rst_n, .i_in_valid, .i_in_ready(o_in_ready), .i_in_item,
        .i_out_valid(o_out_valid), .i_out_ready, .i_out_item(o_out_item),
        .i_cfg_valid, .i_cfg_ready(o_cfg_ready), .i_cfg_index, .i_cfg_data,
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        i_out_ready <= ($urandom_range(99) >= stall_pct);
        if (cycles > 400000) begin
            $display("Verification failed");
            $finish;
        end
    end

    function automatic rprq_pkg::t_in_item rand_item();
        logic [95:0] raw;
        raw = {$urandom, $urandom, $urandom};
        return raw[$bits(rprq_pkg::t_in_item)-1:0];
    endfunction

    // valid drops after each transfer; the block is busy then anyway
    task automatic send(input rprq_pkg::t_in_item it);
        while (send_idle > 0 && $urandom_range(99) < send_idle) @(posedge i_clk);
        i_in_valid <= 1'b1;
        i_in_item <= it;
        do @(posedge i_clk); while (!o_in_ready);
        i_in_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic enq(input logic [1:0] pl, input logic wr, input logic comp,
                       input logic [rprq_pkg::ADDR_W-1:0] a, input logic [15:0] c);
        rprq_pkg::t_in_item it;
        it.command = rprq_pkg::CMD_ENQ;
        it.placement = pl;
        it.is_write = wr;
        it.in_composite = comp;
        it.block_address = a;
        it.sector_count = c;
        it.request_tag = 8'($urandom);
        send(it);
    endtask

    task automatic cmd(input logic [1:0] c);
        rprq_pkg::t_in_item it;
        it = rand_item();
        it.command = c;
        send(it);
    endtask

    task automatic drain();
        while (pending != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [7:0] idx, input logic [23:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic random_item(input int mode);
        rprq_pkg::t_in_item it;
        int k;
        k = $urandom_range(99);
        it = rand_item();
        if (k < 45) begin
            it.command = rprq_pkg::CMD_ENQ;
            it.placement = rprq_pkg::PL_ORDERED;
            it.in_composite = ($urandom_range(19) == 0);
            if (it.is_write && $urandom_range(1)) begin
                it.block_address = run_addr;
                it.sector_count = 16'($urandom_range(mode ? 600 : 40));
                run_addr = run_addr + it.sector_count;
            end
        end else if (k < 55) begin
            it.command = rprq_pkg::CMD_ENQ;
            it.placement = 2'($urandom_range(3));
        end else if (k < 90) begin
            it.command = rprq_pkg::CMD_DEQ;
        end else if (k < 92) begin
            it.command = rprq_pkg::CMD_CLEAR;
        end else if (k < 94) begin
            it.command = rprq_pkg::CMD_NOP;
        end else begin
            it.command = rprq_pkg::CMD_ENQ;
            it.placement = rprq_pkg::PL_TAIL;
        end
        send(it);
    endtask

    initial begin
        run_addr = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extremes, every command, empty/full, composite, walk
        cmd(rprq_pkg::CMD_DEQ);
        enq(rprq_pkg::PL_TAIL, 1'b0, 1'b0, '1, 16'hFFFF);
        enq(rprq_pkg::PL_HEAD, 1'b1, 1'b1, '0, 16'h0000);
        enq(rprq_pkg::PL_ORDERED, 1'b1, 1'b0, 48'h100, 16'd8);
        enq(rprq_pkg::PL_ORDERED, 1'b1, 1'b0, 48'h108, 16'd8);
        enq(rprq_pkg::PL_ORDERED, 1'b0, 1'b0, 48'h5, 16'd1);
        enq(rprq_pkg::PL_ORDERED, 1'b0, 1'b1, 48'h6, 16'd1);
        enq(rprq_pkg::PL_ALT, 1'b1, 1'b0, 48'h7, 16'd2);
        cmd(rprq_pkg::CMD_NOP);
        cmd(rprq_pkg::CMD_DEQ);
        cmd(rprq_pkg::CMD_CLEAR);
        for (int i = 0; i < 34; i++)
            enq(rprq_pkg::PL_TAIL, i[0], 1'b0, 48'(i), 16'(i));
        cmd(rprq_pkg::CMD_CLEAR);
        drain();
        write_reg(rprq_pkg::REG_INTERVAL, 24'd0);
        write_reg(rprq_pkg::REG_BUDGET, 24'd0);
        enq(rprq_pkg::PL_ORDERED, 1'b1, 1'b0, 48'h200, 16'd4);
        enq(rprq_pkg::PL_ORDERED, 1'b1, 1'b0, 48'h204, 16'd4);
        enq(rprq_pkg::PL_ORDERED, 1'b0, 1'b0, 48'h9, 16'd1);
        for (int i = 0; i < 4; i++) cmd(rprq_pkg::CMD_DEQ);
        cmd(rprq_pkg::CMD_DEQ);

        for (int ph = 0; ph < 5; ph++) begin
            drain();
            case (ph)
                0: begin
                    write_reg(rprq_pkg::REG_INTERVAL, 24'd1);
                    write_reg(rprq_pkg::REG_BUDGET, 24'hFFFFFF);
                end
                1: begin
                    write_reg(rprq_pkg::REG_INTERVAL, 24'd255);
                    write_reg(rprq_pkg::REG_BUDGET, 24'd100);
                end
                2: begin
                    write_reg(rprq_pkg::REG_INTERVAL, 24'd3);
                    write_reg(rprq_pkg::REG_BUDGET, 24'd2048);
                end
                3: begin
                    write_reg(rprq_pkg::REG_INTERVAL, 24'd2);
                    write_reg(rprq_pkg::REG_BUDGET, 24'd500);
                end
                default: begin
                    write_reg(rprq_pkg::REG_INTERVAL, 24'd16);
                    write_reg(rprq_pkg::REG_BUDGET, 24'd30);
                end
            endcase
            send_idle = (ph == 1 || ph == 4) ? 49 : (ph == 3 ? 30 : 0);
            stall_pct = (ph == 2 || ph == 4) ? 49 : (ph == 3 ? 30 : 0);
            for (int n = 0; n < 240; n++) begin
                random_item(ph & 1);
                if (n == 120) while (pending != 0) @(posedge i_clk);
            end
        end

        stall_pct = 0;
        drain();
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule

FILE: filelist.f
src/rprq_pkg.sv
src/rprq_cell.sv
src/read_priority_request_queue.sv
src/rprq_checker.sv
tb/read_priority_request_queue_checker.sv
tb/read_priority_request_queue_test.sv
